FILE: hw/rtl/skmc_pkg.sv
// ----------------------------------------------------------------------------
// Sky model coefficient cooker package
// Shared constants, payload types and controller command types.
// ----------------------------------------------------------------------------
package skmc_pkg;

  localparam int STORE_DEPTH     = 4096;
  localparam int TURBIDITY_ROWS  = 10;
  localparam int SHAPE_COEFFS    = 9;
  localparam int BLEND_TERMS     = 6;
  localparam int SHAPE_ALB_WORDS = SHAPE_COEFFS * BLEND_TERMS * TURBIDITY_ROWS;
  localparam int RAD_ALB_WORDS   = BLEND_TERMS * TURBIDITY_ROWS;
  localparam int CHANNEL_WORDS   = 2 * SHAPE_ALB_WORDS + 2 * RAD_ALB_WORDS;
  localparam int RAM_AW          = $clog2(STORE_DEPTH);
  localparam int ADDR_W          = $clog2(4 * CHANNEL_WORDS);
  localparam int ROW_W           = $clog2(TURBIDITY_ROWS + 1);

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [11:0]        store_address;
    logic signed [31:0] store_word;
    logic [1:0]         channel;
    logic [11:0]        turbidity;
    logic [16:0]        albedo;
    logic [16:0]        elevation_fraction;
  } request_t;

  typedef struct packed {
    logic [3:0]         coefficient_index;
    logic signed [31:0] coefficient_value;
    logic               last;
  } result_t;

  typedef struct packed {
    logic       root_sq;
    logic       root_cube;
    logic [4:0] root_bit;
    logic       power;
    logic       bern_mul;
    logic       bern_scale;
    logic [2:0] kidx;
    logic       issue;
    logic [3:0] coeff;
    logic [1:0] slot;
    logic       last_row;
    logic       push;
  } cmd_t;

  typedef struct packed {
    logic top;
    logic done;
    logic out_free;
  } status_t;

  function automatic logic [3:0] binom5(input logic [2:0] k);
    case (k)
      3'd1, 3'd4: binom5 = 4'd5;
      3'd2, 3'd3: binom5 = 4'd10;
      default:    binom5 = 4'd1;
    endcase
  endfunction

endpackage

FILE: hw/rtl/skmc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module skmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/skmc_dp.sv
// ----------------------------------------------------------------------------
// Sky model coefficient cooker datapath
// Cube root, Bernstein weights, store reads, row blend and output register.
// ----------------------------------------------------------------------------
module skmc_dp (
  input  logic               clk,
  input  logic               rst,
  input  skmc_pkg::request_t request,
  input  logic               request_take,
  input  skmc_pkg::cmd_t     cmd,
  output skmc_pkg::status_t  st,
  output logic               result_valid,
  input  logic               result_stall,
  output skmc_pkg::result_t  result
);
  import skmc_pkg::*;

  typedef struct packed {
    logic       v;
    logic [2:0] kidx;
    logic       first;
    logic       endrow;
    logic [1:0] slot;
    logic       last;
    logic       oob;
  } tag_t;

  logic [ROW_W-1:0]  n;
  logic [7:0]        r;
  logic [16:0]       alb;
  logic [16:0]       elev;
  logic [1:0]        chan;
  logic [16:0]       y;
  logic [33:0]       sq;
  logic [16:0]       ps_run;
  logic [16:0]       pu_run;
  logic [16:0]       ps [BLEND_TERMS];
  logic [16:0]       pu [BLEND_TERMS];
  logic [16:0]       btmp;
  logic [19:0]       b [BLEND_TERMS];
  logic [24:0]       w [4];
  tag_t              p1, p2, p3;
  logic              p4_v;
  logic [1:0]        p4_slot;
  logic              p4_last;
  logic signed [52:0] prod;
  logic signed [55:0] acc;
  logic signed [63:0] wprod;
  logic signed [63:0] total;
  logic              done;

  logic [12:0]       tur;
  logic [12:0]       tur_c;
  logic [16:0]       cand;
  logic [50:0]       cube;
  logic [16:0]       u;
  logic [16:0]       ps_next;
  logic [16:0]       pu_next;
  logic              rad;
  logic [ROW_W-1:0]  row_sel;
  logic [ADDR_W-1:0] addr;
  logic              oob;
  logic              we;
  logic [31:0]       rdata;
  logic signed [31:0] word;
  logic signed [39:0] row;
  logic signed [63:0] total_sh;
  logic signed [31:0] sat;

  always_comb begin
    tur   = {1'b0, request.turbidity};
    tur_c = tur;
    if (tur < 13'd256) begin
      tur_c = 13'd256;
    end else if (tur > 13'(TURBIDITY_ROWS * 256)) begin
      tur_c = 13'(TURBIDITY_ROWS * 256);
    end
  end

  assign cand    = y | (17'd1 << cmd.root_bit);
  assign cube    = 51'(sq) * 51'(cand);
  assign u       = 17'(18'd65536 - 18'(y));
  assign ps_next = 17'((34'(ps_run) * 34'(y)) >> 16);
  assign pu_next = 17'((34'(pu_run) * 34'(u)) >> 16);

  assign rad     = (cmd.coeff == 4'(SHAPE_COEFFS));
  assign row_sel = n - ROW_W'(1) + ROW_W'(cmd.slot[1]);

  always_comb begin
    addr = ADDR_W'(chan) * ADDR_W'(CHANNEL_WORDS);
    if (rad) begin
      addr = addr + ADDR_W'(2 * SHAPE_ALB_WORDS)
           + (cmd.slot[0] ? ADDR_W'(RAD_ALB_WORDS) : '0)
           + ADDR_W'(row_sel) * ADDR_W'(BLEND_TERMS)
           + ADDR_W'(cmd.kidx);
    end else begin
      addr = addr + ADDR_W'(cmd.coeff)
           + (cmd.slot[0] ? ADDR_W'(SHAPE_ALB_WORDS) : '0)
           + ADDR_W'(row_sel) * ADDR_W'(SHAPE_COEFFS * BLEND_TERMS)
           + ADDR_W'(cmd.kidx) * ADDR_W'(SHAPE_COEFFS);
    end
  end

  assign oob = (ADDR_W'(addr) >= ADDR_W'(STORE_DEPTH));
  assign we  = request_take && (request.operation == OP_WRITE)
            && ({2'b00, request.store_address} < 14'(STORE_DEPTH));

  skmc_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (RAM_AW'(request.store_address)),
    .wdata (request.store_word),
    .raddr (RAM_AW'(addr)),
    .rdata (rdata)
  );

  assign word     = p1.oob ? 32'sd0 : $signed(rdata);
  assign row      = 40'(acc >>> 16);
  assign total_sh = total >>> 24;

  always_comb begin
    if (total_sh > 64'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (total_sh < -64'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = total_sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (request_take && request.operation == OP_COMPUTE) begin
      n      <= ROW_W'(tur_c >> 8);
      r      <= tur_c[7:0];
      alb    <= (request.albedo > 17'd65536) ? 17'd65536 : request.albedo;
      elev   <= (request.elevation_fraction > 17'd65536) ? 17'd65536
              : request.elevation_fraction;
      chan   <= request.channel;
      y      <= '0;
      ps_run <= 17'd65536;
      pu_run <= 17'd65536;
      ps[0]  <= 17'd65536;
      pu[0]  <= 17'd65536;
    end
    if (cmd.root_sq) begin
      sq <= 34'(cand) * 34'(cand);
    end
    if (cmd.root_cube && (cube <= {2'b00, elev, 32'd0})) begin
      y <= cand;
    end
    if (cmd.power) begin
      ps_run         <= ps_next;
      pu_run         <= pu_next;
      ps[cmd.kidx]   <= ps_next;
      pu[cmd.kidx]   <= pu_next;
      w[0] <= 25'(26'(17'd65536 - alb) * 26'(9'd256 - 9'(r)));
      w[1] <= 25'(26'(alb) * 26'(9'd256 - 9'(r)));
      w[2] <= 25'(26'(17'd65536 - alb) * 26'(r));
      w[3] <= 25'(26'(alb) * 26'(r));
    end
    if (cmd.bern_mul) begin
      btmp <= 17'((34'(pu[3'(BLEND_TERMS - 1) - cmd.kidx]) * 34'(ps[cmd.kidx])) >> 16);
    end
    if (cmd.bern_scale) begin
      b[cmd.kidx] <= 20'(btmp) * 20'(binom5(cmd.kidx));
    end

    prod <= $signed({1'b0, b[p1.kidx]}) * word;
    if (p2.v) begin
      acc <= (p2.first ? 56'sd0 : acc) + 56'(prod);
    end
    wprod <= 64'($signed({1'b0, w[p3.slot]})) * 64'(row);
    p4_slot <= p3.slot;
    p4_last <= p3.last;
    if (p4_v) begin
      total <= ((p4_slot == 2'd0) ? 64'sd0 : total) + wprod;
    end

    if (cmd.push) begin
      result.coefficient_index <= cmd.coeff;
      result.coefficient_value <= sat;
      result.last              <= rad;
    end

    if (rst) begin
      p1.v         <= 1'b0;
      p2.v         <= 1'b0;
      p3.v         <= 1'b0;
      p4_v         <= 1'b0;
      done         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      p1.v      <= cmd.issue;
      p1.kidx   <= cmd.kidx;
      p1.first  <= (cmd.kidx == 3'd0);
      p1.endrow <= (cmd.kidx == 3'(BLEND_TERMS - 1));
      p1.slot   <= cmd.slot;
      p1.last   <= cmd.last_row && (cmd.kidx == 3'(BLEND_TERMS - 1));
      p1.oob    <= oob;
      p2        <= p1;
      p3        <= p2;
      p4_v      <= p3.v && p3.endrow;
      if (cmd.push) begin
        done <= 1'b0;
      end else if (p4_v && p4_last) begin
        done <= 1'b1;
      end
      if (cmd.push) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign st.top      = (n == ROW_W'(TURBIDITY_ROWS));
  assign st.done     = done;
  assign st.out_free = !result_valid || !result_stall;
endmodule

FILE: hw/rtl/skmc_ctrl.sv
// ----------------------------------------------------------------------------
// Sky model coefficient cooker controller
// Sequences the root search, weight setup, store reads and result pushes.
// ----------------------------------------------------------------------------
module skmc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  input  logic              operation,
  output logic              request_stall,
  input  skmc_pkg::status_t st,
  output skmc_pkg::cmd_t    cmd
);
  import skmc_pkg::*;

  typedef enum logic [3:0] {
    IDLE, ROOT_SQ, ROOT_CUBE, POWER, BERN_MUL, BERN_SCALE, ISSUE, DRAIN, PUSH
  } state_t;

  state_t     state;
  logic [4:0] bit_cnt;
  logic [2:0] k_cnt;
  logic [1:0] slot;
  logic [3:0] coeff;
  logic [1:0] last_slot;

  assign last_slot     = st.top ? 2'd1 : 2'd3;
  assign request_stall = (state != IDLE);

  always_comb begin
    cmd            = '0;
    cmd.root_bit   = bit_cnt;
    cmd.kidx       = k_cnt;
    cmd.coeff      = coeff;
    cmd.slot       = slot;
    cmd.root_sq    = (state == ROOT_SQ);
    cmd.root_cube  = (state == ROOT_CUBE);
    cmd.power      = (state == POWER);
    cmd.bern_mul   = (state == BERN_MUL);
    cmd.bern_scale = (state == BERN_SCALE);
    cmd.issue      = (state == ISSUE);
    cmd.last_row   = (slot == last_slot);
    cmd.push       = (state == PUSH) && st.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      bit_cnt <= '0;
      k_cnt   <= '0;
      slot    <= '0;
      coeff   <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (request_valid && operation == OP_COMPUTE) begin
            state   <= ROOT_SQ;
            bit_cnt <= 5'd16;
          end
        end
        ROOT_SQ: begin
          state <= ROOT_CUBE;
        end
        ROOT_CUBE: begin
          if (bit_cnt == 5'd0) begin
            state <= POWER;
            k_cnt <= 3'd1;
          end else begin
            state   <= ROOT_SQ;
            bit_cnt <= bit_cnt - 5'd1;
          end
        end
        POWER: begin
          if (k_cnt == 3'(BLEND_TERMS - 1)) begin
            state <= BERN_MUL;
            k_cnt <= 3'd0;
          end else begin
            k_cnt <= k_cnt + 3'd1;
          end
        end
        BERN_MUL: begin
          state <= BERN_SCALE;
        end
        BERN_SCALE: begin
          if (k_cnt == 3'(BLEND_TERMS - 1)) begin
            state <= ISSUE;
            k_cnt <= 3'd0;
            slot  <= 2'd0;
            coeff <= 4'd0;
          end else begin
            state <= BERN_MUL;
            k_cnt <= k_cnt + 3'd1;
          end
        end
        ISSUE: begin
          if (k_cnt == 3'(BLEND_TERMS - 1)) begin
            k_cnt <= 3'd0;
            if (slot == last_slot) begin
              state <= DRAIN;
            end else begin
              slot <= slot + 2'd1;
            end
          end else begin
            k_cnt <= k_cnt + 3'd1;
          end
        end
        DRAIN: begin
          if (st.done) begin
            state <= PUSH;
          end
        end
        PUSH: begin
          if (st.out_free) begin
            if (coeff == 4'(SHAPE_COEFFS)) begin
              state <= IDLE;
            end else begin
              state <= ISSUE;
              coeff <= coeff + 4'd1;
              slot  <= 2'd0;
              k_cnt <= 3'd0;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_no_stale_done: assert property (@(posedge clk) disable iff (rst)
    (state == ISSUE) |-> !st.done)
    else $error("finished total still pending while issuing reads");

  a_push_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> !st.done)
    else $error("finished total not cleared after push");

  a_done_draining: assert property (@(posedge clk) disable iff (rst)
    st.done |-> (state == DRAIN || state == PUSH))
    else $error("finished total outside drain");
endmodule

FILE: hw/rtl/sky_model_coefficient_cooker_unit.sv
// A write request gives no result.
// A compute request first runs the setup (17-bit cube root search, powers and
// weights), then per coefficient makes 6*R reads, runs them through the shared
// multiply-accumulate pipeline and pushes the result, R = 4 or 2 at top turbidity.
// One request at a time; the store read port sets the pace. Reset clears control
// state only; the coefficient store holds no reset value.
// ----------------------------------------------------------------------------
// Sky model coefficient cooker
// Blends stored sky model coefficients for one channel into nine shape values
// and one radiance.
// ----------------------------------------------------------------------------
module sky_model_coefficient_cooker_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               request_valid,
  output logic               request_stall,
  input  skmc_pkg::request_t request,
  output logic               result_valid,
  input  logic               result_stall,
  output skmc_pkg::result_t  result
);
  import skmc_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    request_take;

  assign request_take = request_valid && !request_stall;

  skmc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .operation     (request.operation),
    .request_stall (request_stall),
    .st            (st),
    .cmd           (cmd)
  );

  skmc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .request_take (request_take),
    .cmd          (cmd),
    .st           (st),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );
endmodule

FILE: sim/sky_model_coefficient_cooker_unit_test.sv
// ----------------------------------------------------------------------------
// Sky model coefficient cooker testbench
// Fills the coefficient store, runs a directed table of requests and then
// random write and compute requests with random idling on request and result sides.
// Every result is checked against a predictor of the channel blend or a typed row's value.
// ----------------------------------------------------------------------------
module sky_model_coefficient_cooker_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import skmc_pkg::*;

  localparam int RANDOM_REQUESTS = 230;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint BINOM[6] = '{1, 5, 10, 10, 5, 1};

  typedef struct {
    request_t req;
    bit       typed;
    int       typed_value;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     request_valid = 1'b0;
  logic     request_stall;
  request_t request = '0;
  logic     result_valid;
  logic     result_stall = 1'b0;
  result_t  result;

  logic signed [31:0] store_image [STORE_DEPTH];
  longint             bern_weights [6];
  result_t            pending_coeffs [$];
  stim_row_t          directed_rows [];
  int                 errors = 0;
  int                 idle_cycles = 0;
  bit                 quiet = 1'b0;
  bit                 hold_off = 1'b0;

  sky_model_coefficient_cooker_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint stored_word(longint addr);
    if (addr >= STORE_DEPTH) return 0;
    return longint'(store_image[addr]);
  endfunction

  function automatic longint row_blend(longint addr, longint stride);
    longint acc;
    acc = 0;
    for (int k = 0; k < 6; k++) acc += bern_weights[k] * stored_word(addr + k * stride);
    return acc >>> 16;
  endfunction

  function automatic void cook_channel(request_t rq);
    longint t, a, e, s, u, n, r, base, c, stride, rowsz, albsz, start, total, v;
    longint ps [6];
    longint pu [6];
    longint w [4];
    result_t res;
    t = rq.turbidity;
    if (t < 256) t = 256;
    if (t > TURBIDITY_ROWS * 256) t = TURBIDITY_ROWS * 256;
    a = (rq.albedo > 65536) ? 65536 : rq.albedo;
    e = (rq.elevation_fraction > 65536) ? 65536 : rq.elevation_fraction;
    n = t >> 8;
    r = t & 255;
    s = 0;
    for (int bitpos = 16; bitpos >= 0; bitpos--) begin
      c = s | (longint'(1) << bitpos);
      if (c * c * c <= (e << 32)) s = c;
    end
    u = 65536 - s;
    ps[0] = 65536;
    pu[0] = 65536;
    for (int k = 1; k < 6; k++) begin
      ps[k] = (ps[k-1] * s) >> 16;
      pu[k] = (pu[k-1] * u) >> 16;
    end
    for (int k = 0; k < 6; k++) bern_weights[k] = BINOM[k] * ((pu[5-k] * ps[k]) >> 16);
    w[0] = (65536 - a) * (256 - r);
    w[1] = a * (256 - r);
    w[2] = (65536 - a) * r;
    w[3] = a * r;
    base = longint'(rq.channel) * CHANNEL_WORDS;
    for (int i = 0; i <= SHAPE_COEFFS; i++) begin
      stride = (i == SHAPE_COEFFS) ? 1 : SHAPE_COEFFS;
      rowsz = (i == SHAPE_COEFFS) ? 6 : SHAPE_COEFFS * 6;
      albsz = (i == SHAPE_COEFFS) ? RAD_ALB_WORDS : SHAPE_ALB_WORDS;
      start = (i == SHAPE_COEFFS) ? base + 2 * SHAPE_ALB_WORDS : base + i;
      total = w[0] * row_blend(start + (n - 1) * rowsz, stride)
            + w[1] * row_blend(start + albsz + (n - 1) * rowsz, stride);
      if (n < TURBIDITY_ROWS) begin
        total += w[2] * row_blend(start + n * rowsz, stride)
               + w[3] * row_blend(start + albsz + n * rowsz, stride);
      end
      v = total >>> 24;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      res.coefficient_index = 4'(i);
      res.coefficient_value = 32'(v);
      res.last = (i == SHAPE_COEFFS);
      pending_coeffs.push_back(res);
    end
  endfunction

  function automatic request_t make_request(logic op, int addr, int word, int ch, int t,
                                            int a, int e);
    request_t rq;
    rq.operation = op;
    rq.store_address = 12'(addr);
    rq.store_word = 32'(word);
    rq.channel = 2'(ch);
    rq.turbidity = 12'(t);
    rq.albedo = 17'(a);
    rq.elevation_fraction = 17'(e);
    return rq;
  endfunction

  function automatic stim_row_t row(request_t rq, bit typed, int value);
    stim_row_t sr;
    sr.req = rq;
    sr.typed = typed;
    sr.typed_value = value;
    return sr;
  endfunction

  task automatic send_request(request_t rq, bit typed, int typed_value);
    int first;
    request <= rq;
    request_valid <= 1'b1;
    do @(posedge clk); while (request_stall);
    if (rq.operation == OP_WRITE) begin
      store_image[rq.store_address] = rq.store_word;
    end else begin
      first = pending_coeffs.size();
      cook_channel(rq);
      if (typed) begin
        for (int i = first; i < pending_coeffs.size(); i++)
          pending_coeffs[i].coefficient_value = typed_value;
      end
    end
    if (!quiet && $urandom_range(0, 3) == 0) begin
      request_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  function automatic request_t random_request();
    int t, a, e;
    if ($urandom_range(0, 9) < 3)
      return make_request(OP_WRITE, $urandom_range(0, 4095), $urandom, 0, 0, 0, 0);
    t = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(256, 2560);
    a = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, 65536);
    e = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, 65536);
    return make_request(OP_COMPUTE, 0, 0, $urandom_range(0, 3), t, a, e);
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_coeffs.size() == 0) begin
        errors++;
        $display("%0t unexpected result index %0d value %0d last %0b", $realtime,
                 result.coefficient_index, result.coefficient_value, result.last);
      end else begin
        if (result !== pending_coeffs[0]) begin
          errors++;
          $display("%0t mismatch: expected index %0d value %0d last %0b, got %0d %0d %0b",
                   $realtime, pending_coeffs[0].coefficient_index,
                   pending_coeffs[0].coefficient_value, pending_coeffs[0].last,
                   result.coefficient_index, result.coefficient_value, result.last);
        end
        void'(pending_coeffs.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((request_valid && !request_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL sky_model_coefficient_cooker_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        result_stall <= 1'b1;
        repeat (400) @(posedge clk);
        result_stall <= 1'b0;
        hold_off = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // The channel two block stays zero so that its blends are known to be zero.
    for (int addr = 0; addr < STORE_DEPTH; addr++) begin
      send_request(make_request(OP_WRITE, addr,
                                (addr >= 2 * CHANNEL_WORDS && addr < 3 * CHANNEL_WORDS) ?
                                0 : $urandom_range(0, 32'h003FFFFF) - 32'h00200000,
                                0, 0, 0, 0), 1'b0, 0);
    end
    directed_rows = '{
      row(make_request(OP_COMPUTE, 0, 0, 2, 256, 0, 0), 1'b1, 0),
      row(make_request(OP_COMPUTE, 0, 0, 2, 2560, 65536, 65536), 1'b1, 0),
      row(make_request(OP_COMPUTE, 0, 0, 2, 4095, 131071, 131071), 1'b1, 0),
      row(make_request(OP_COMPUTE, 0, 0, 2, 0, 32768, 1000), 1'b1, 0),
      row(make_request(OP_WRITE, 0, 32'h7FFFFFFF, 0, 0, 0, 0), 1'b0, 0),
      row(make_request(OP_WRITE, 4095, 32'h80000000, 0, 0, 0, 0), 1'b0, 0),
      row(make_request(OP_COMPUTE, 0, 0, 0, 256, 0, 0), 1'b0, 0),
      row(make_request(OP_COMPUTE, 0, 0, 0, 2560, 65536, 65536), 1'b0, 0),
      row(make_request(OP_COMPUTE, 0, 0, 1, 0, 131071, 0), 1'b0, 0),
      row(make_request(OP_COMPUTE, 0, 0, 1, 4095, 0, 131071), 1'b0, 0),
      row(make_request(OP_COMPUTE, 0, 0, 3, 1000, 20000, 40000), 1'b0, 0),
      row(make_request(OP_COMPUTE, 0, 0, 3, 2560, 65535, 1), 1'b0, 0),
      row(make_request(OP_COMPUTE, 0, 0, 0, 2559, 1, 65535), 1'b0, 0),
      row(make_request(OP_COMPUTE, 0, 0, 1, 511, 49152, 8), 1'b0, 0)
    };
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].typed_value);
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 80) hold_off = 1'b1;
      if (i == 150) begin
        request_valid <= 1'b0;
        wait (pending_coeffs.size() == 0);
        @(posedge clk);
      end
      if (i == RANDOM_REQUESTS - 40) quiet = 1'b1;
      send_request(random_request(), 1'b0, 0);
    end
    request_valid <= 1'b0;
    wait (pending_coeffs.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("PASS sky_model_coefficient_cooker_unit");
    end else begin
      $display("FAIL sky_model_coefficient_cooker_unit");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/skmc_pkg.sv
hw/rtl/skmc_ram.sv
hw/rtl/skmc_dp.sv
hw/rtl/skmc_ctrl.sv
hw/rtl/sky_model_coefficient_cooker_unit.sv
sim/sky_model_coefficient_cooker_unit_test.sv
